[rtl/i2cbb_pkg.sv]
// Shared types, mode codes and line-level tables for the I2C bit-bang master.
`default_nettype none

package i2cbb_pkg;

    // Command mode codes
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_STOP  = 3'd1;
    localparam logic [2:0] MODE_ACK   = 3'd2;
    localparam logic [2:0] MODE_NACK  = 3'd3;
    localparam logic [2:0] MODE_WAIT  = 3'd4;
    localparam logic [2:0] MODE_SEND  = 3'd5;
    localparam logic [2:0] MODE_READ  = 3'd6;
    localparam logic [2:0] MODE_NONE  = 3'd7;

    localparam int BYTE_BITS = 8;

    // Beat widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // One queued command
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic [7:0] bus_sda_bits;
    } cmd_t;

    // Line levels of one interval
    typedef struct packed {
        logic scl;
        logic sda;
    } line_t;

    // Last phase index inside one bit slot of a mode
    function automatic logic [2:0] last_phase(input logic [2:0] mode);
        logic [2:0] r;
        unique case (mode)
            MODE_START: r = 3'd1;
            MODE_STOP:  r = 3'd1;
            MODE_ACK:   r = 3'd4;
            MODE_NACK:  r = 3'd2;
            MODE_WAIT:  r = 3'd2;
            MODE_SEND:  r = 3'd3;
            MODE_READ:  r = 3'd2;
            default:    r = 3'd0;
        endcase
        return r;
    endfunction

    // True for modes that run over eight bit slots
    function automatic logic is_byte_mode(input logic [2:0] mode);
        return (mode == MODE_SEND) || (mode == MODE_READ);
    endfunction

    // SCL/SDA for a given mode, phase and data bit; sda_prev is the level held
    function automatic line_t line_level(input logic [2:0] mode,
                                         input logic [2:0] phase,
                                         input logic       data_bit,
                                         input logic       sda_prev);
        line_t l;
        l.scl = 1'b0;
        l.sda = 1'b1;
        unique case (mode)
            MODE_START: begin
                l.scl = 1'b1;
                l.sda = (phase == 3'd0);
            end
            MODE_STOP: begin
                l.scl = 1'b1;
                l.sda = (phase != 3'd0);
            end
            MODE_ACK: begin
                l.scl = (phase == 3'd2);
                l.sda = (phase == 3'd0) || (phase == 3'd4);
            end
            MODE_NACK, MODE_WAIT, MODE_READ: begin
                l.scl = (phase == 3'd1);
                l.sda = 1'b1;
            end
            MODE_SEND: begin
                l.scl = (phase == 3'd2);
                l.sda = (phase == 3'd0) ? sda_prev : data_bit;
            end
            default: begin
                l.scl = 1'b1;
                l.sda = 1'b1;
            end
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

[rtl/i2cbb_front.sv]
// Front end: accepts command beats, drops unused modes, queues the rest.
`default_nettype none

module i2cbb_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,   // mode[2:0], tx_byte[10:3], bus_sda_bits[18:11]
    output logic                     q_valid,
    output i2cbb_pkg::cmd_t          q_cmd,
    input  wire logic                q_pop
);
    import i2cbb_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    cmd_t       in_cmd;
    logic       push;

    // Unpack the input beat
    assign in_cmd.mode         = s_tdata[2:0];
    assign in_cmd.tx_byte      = s_tdata[10:3];
    assign in_cmd.bus_sda_bits = s_tdata[18:11];

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && (in_cmd.mode != MODE_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/i2cbb_back.sv]
// Back end: steps through the line states of one command into an output register.
`default_nettype none

module i2cbb_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                q_valid,
    input  wire i2cbb_pkg::cmd_t     q_cmd,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [15:0]              m_tdata,   // scl_level[0], sda_level[1], rx_byte[9:2], nack_seen[10]
    output logic                     m_tlast
);
    import i2cbb_pkg::*;

    cmd_t       cmd_reg;
    logic       busy_reg,  busy_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] bit_reg,   bit_next;
    logic       sda_cur_reg;
    logic       out_valid_reg, out_valid_next;
    logic       scl_out_reg, sda_out_reg, nack_out_reg, last_out_reg;
    logic [7:0] rx_out_reg;

    logic       fire;
    logic       is_last;
    logic       data_bit;
    line_t      lvl;

    // Current interval
    assign fire     = busy_reg && (!out_valid_reg || m_tready);
    assign is_last  = (phase_reg == last_phase(cmd_reg.mode)) &&
                      (!is_byte_mode(cmd_reg.mode) || (bit_reg == 3'(BYTE_BITS - 1)));
    assign data_bit = cmd_reg.tx_byte[3'(BYTE_BITS - 1) - bit_reg];
    assign lvl      = line_level(cmd_reg.mode, phase_reg, data_bit, sda_cur_reg);
    assign q_pop    = q_valid && (!busy_reg || (fire && is_last));

    // Sequencer control
    always_comb begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            out_valid_next = 1'b1;
            if (is_last) begin
                busy_next  = 1'b0;
                phase_next = 3'd0;
                bit_next   = 3'd0;
            end else if (phase_reg == last_phase(cmd_reg.mode)) begin
                phase_next = 3'd0;
                bit_next   = bit_reg + 3'd1;
            end else begin
                phase_next = phase_reg + 3'd1;
            end
        end
        if (q_pop) begin
            busy_next  = 1'b1;
            phase_next = 3'd0;
            bit_next   = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= 3'd0;
            bit_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            sda_cur_reg   <= 1'b1;
        end else begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                sda_cur_reg <= lvl.sda;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        if (fire) begin
            scl_out_reg  <= lvl.scl;
            sda_out_reg  <= lvl.sda;
            last_out_reg <= is_last;
            rx_out_reg   <= (is_last && cmd_reg.mode == MODE_READ) ? cmd_reg.bus_sda_bits : 8'd0;
            nack_out_reg <= is_last && (cmd_reg.mode == MODE_WAIT) && cmd_reg.bus_sda_bits[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_out_reg;
    assign m_tdata  = {5'd0, nack_out_reg, rx_out_reg, sda_out_reg, scl_out_reg};

endmodule

`default_nettype wire

[rtl/i2c_bitbang_master.sv]
// Top level of the I2C bit-bang master: command queue front end and line sequencer.
`default_nettype none

// Each accepted command expands into a run of SCL/SDA line states, one result
// beat per bus delay interval: start 2, stop 2, ack 5, nack 3, wait ack 3,
// send byte 32 and read byte 24 beats. The sequencer emits one beat per clock
// while the result side is ready, and takes the next command from a two-entry
// command queue as it issues the last beat of the current one. Mode 7 is
// accepted and discarded without a result.
// The sampled byte (read byte) and the ack flag (wait ack) appear on the last
// beat of the command, marked by m_tlast; they are zero on all other beats.
// SDA is released high after reset.

module i2c_bitbang_master (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // mode[2:0], tx_byte[10:3], bus_sda_bits[18:11]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // scl_level[0], sda_level[1], rx_byte[9:2], nack_seen[10]
    output logic             m_tlast
);
    import i2cbb_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    i2cbb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    i2cbb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
